[rtl/fmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fmq_pkg;

  // Storage shape of the queue.
  localparam int DEPTH     = 16;
  localparam int ID_BITS   = 8;
  localparam int PRIO_BITS = 6;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths on the streams.
  localparam int OPCODE_W    = 3;
  localparam int ID_FIELD_W  = 8;
  localparam int PRIO_FIELD_W = 6;
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = 5;

  localparam int IN_BITS  = OPCODE_W + ID_FIELD_W + PRIO_FIELD_W;
  localparam int OUT_BITS = STATUS_W + ID_FIELD_W + PRIO_FIELD_W + OCC_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Bit positions of the packed fields.
  localparam int IN_ID_LSB    = OPCODE_W;
  localparam int IN_PRIO_LSB  = OPCODE_W + ID_FIELD_W;
  localparam int OUT_ID_LSB   = STATUS_W;
  localparam int OUT_PRIO_LSB = STATUS_W + ID_FIELD_W;
  localparam int OUT_OCC_LSB  = STATUS_W + ID_FIELD_W + PRIO_FIELD_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_SEARCH  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_PEEK    = 3'd3,
    OP_POP     = 3'd4,
    OP_REPRIO  = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_DUPLICATE = 3'd4
  } status_t;

  // Per-cell update command; at most one bit is set in a cycle.
  typedef struct packed {
    logic load;      // write the request entry into this cell
    logic shift;     // take the entry of the next cell up the row
    logic set_prio;  // overwrite the stored priority
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/fmq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One slot of the queue. It holds an id and a priority, matches the id of the
// current request and decides on its own whether it is the maximum entry.
module fmq_cell
  import fmq_pkg::*;
(
  input  wire logic                                 clk,
  input  wire logic [IDX_W-1:0]                     cell_idx,
  input  wire logic                                 held,
  input  wire logic [DEPTH-1:0]                     all_held,
  input  wire logic [DEPTH-1:0][PRIO_BITS-1:0]      all_prio,
  input  wire logic [ID_BITS-1:0]                   req_id,
  input  wire logic [PRIO_BITS-1:0]                 req_prio,
  input  wire cell_cmd_t                            cmd,
  input  wire logic [ID_BITS-1:0]                   nb_id,
  input  wire logic [PRIO_BITS-1:0]                 nb_prio,
  output logic [ID_BITS-1:0]                        slot_id,
  output logic [PRIO_BITS-1:0]                      slot_prio,
  output logic                                      hit,
  output logic                                      is_max
);

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      slot_id   <= req_id;
      slot_prio <= req_prio;
    end else if (cmd.shift) begin
      slot_id   <= nb_id;
      slot_prio <= nb_prio;
    end else if (cmd.set_prio) begin
      slot_prio <= req_prio;
    end
  end

  assign hit = held && (slot_id == req_id);

  // An earlier slot must be strictly beaten, a later one only matched, so
  // exactly one held slot wins and ties go to the oldest entry.
  always_comb begin
    is_max = held;
    for (int j = 0; j < DEPTH; j++) begin
      if (all_held[j] && (IDX_W'(j) != cell_idx)) begin
        if (IDX_W'(j) < cell_idx) begin
          if (!(slot_prio > all_prio[j])) is_max = 1'b0;
        end else begin
          if (slot_prio < all_prio[j]) is_max = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/fifo_tiebreak_max_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                          Content
// --------  ---------  -------------------------------  ------------------------------
// request   in         s_tvalid, s_tready, s_tdata[23:0] opcode, entry_id, priority_req
// response  out        m_tvalid, m_tready, m_tdata[23:0] status, result_id,
//                                                       result_priority, occupancy
//
// Every request item is first captured; then all cells compare in parallel
// and the row is updated and compacted when the request commits.
// One request is in work at a time; s_tready is high only while idle.
// The response sits in an output register, so a new request is captured
// while a response still waits; a stalled response only holds back the
// commit of the request behind it. rst is synchronous and empties the queue.
//
// The queue is a row of DEPTH cells in insertion order. Cell i holds an entry
// whenever i is below the entry count, so the slots carry no valid flops.
// Removing an entry makes every cell at or above it take the contents of its
// upper neighbor in the same cycle, which keeps the order gap-free.
module fifo_tiebreak_max_priority_queue
  import fmq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [2:0] opcode, [10:3] entry_id, [16:11] priority_req, [23:17] zero
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [2:0] status, [10:3] result_id, [16:11] result_priority,
  // [21:17] occupancy, [23:22] zero
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // Captured request.
  logic [OPCODE_W-1:0]  req_op;
  logic [ID_BITS-1:0]   req_id;
  logic [PRIO_BITS-1:0] req_prio;

  logic [CNT_W-1:0] count, count_next;

  // Cell row.
  logic [DEPTH-1:0][ID_BITS-1:0]   cell_id;
  logic [DEPTH-1:0][PRIO_BITS-1:0] cell_prio;
  logic [DEPTH-1:0][ID_BITS-1:0]   nb_id;
  logic [DEPTH-1:0][PRIO_BITS-1:0] nb_prio;
  logic [DEPTH-1:0]                held;
  logic [DEPTH-1:0]                hit;
  logic [DEPTH-1:0]                is_max;
  cell_cmd_t [DEPTH-1:0]           cmd;

  logic                   commit;
  logic                   found;
  logic [DEPTH-1:0]       sel;
  logic [ID_BITS-1:0]     sel_id;
  logic [PRIO_BITS-1:0]   sel_prio;
  logic                   do_load;
  logic                   do_remove;
  logic                   do_reprio;
  status_t                res_status;
  logic [ID_BITS-1:0]     res_id;
  logic [PRIO_BITS-1:0]   res_prio;
  logic [OUT_TDATA_W-1:0] res_word;

  assign s_tready = (state == S_IDLE);

  // The request commits only when the output register is free to take its
  // response; otherwise it waits in S_EXEC with the cells untouched.
  assign commit = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op   <= s_tdata[OPCODE_W-1:0];
      req_id   <= ID_BITS'(s_tdata[IN_ID_LSB +: ID_FIELD_W]);
      req_prio <= PRIO_BITS'(s_tdata[IN_PRIO_LSB +: PRIO_FIELD_W]);
    end
  end

  // Occupancy map and neighbor wiring; the top cell shifts in nothing.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      held[i] = (CNT_W'(i) < count);
      if (i == DEPTH - 1) begin
        nb_id[i]   = '0;
        nb_prio[i] = '0;
      end else begin
        nb_id[i]   = cell_id[i+1];
        nb_prio[i] = cell_prio[i+1];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    fmq_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .held      (held[g]),
      .all_held  (held),
      .all_prio  (cell_prio),
      .req_id    (req_id),
      .req_prio  (req_prio),
      .cmd       (cmd[g]),
      .nb_id     (nb_id[g]),
      .nb_prio   (nb_prio[g]),
      .slot_id   (cell_id[g]),
      .slot_prio (cell_prio[g]),
      .hit       (hit[g]),
      .is_max    (is_max[g])
    );
  end

  // Ids are unique in the row, so hit has at most one bit set, and is_max
  // has exactly one bit set whenever the row is not empty.
  assign found = |hit;
  assign sel   = ((req_op == OP_PEEK) || (req_op == OP_POP)) ? is_max : hit;

  always_comb begin
    sel_id   = '0;
    sel_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        sel_id   = sel_id | cell_id[i];
        sel_prio = sel_prio | cell_prio[i];
      end
    end
  end

  always_comb begin
    res_status = STAT_OK;
    res_id     = '0;
    res_prio   = '0;
    do_load    = 1'b0;
    do_remove  = 1'b0;
    do_reprio  = 1'b0;
    unique case (req_op)
      OP_INSERT: begin
        if (found) begin
          res_status = STAT_DUPLICATE;
        end else if (count >= CNT_W'(DEPTH)) begin
          res_status = STAT_FULL;
        end else begin
          do_load  = 1'b1;
          res_id   = req_id;
          res_prio = req_prio;
        end
      end
      OP_SEARCH, OP_DELETE, OP_REPRIO: begin
        if (!found) begin
          res_status = STAT_NOT_FOUND;
        end else begin
          res_id    = sel_id;
          res_prio  = (req_op == OP_REPRIO) ? req_prio : sel_prio;
          do_remove = (req_op == OP_DELETE);
          do_reprio = (req_op == OP_REPRIO);
        end
      end
      OP_PEEK, OP_POP: begin
        if (count == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          res_id    = sel_id;
          res_prio  = sel_prio;
          do_remove = (req_op == OP_POP);
        end
      end
      default: begin
        // Unused opcodes leave the queue alone and report success.
      end
    endcase
  end

  // A removal shifts the selected cell and every cell above it.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      logic at_or_above;
      at_or_above = 1'b0;
      for (int j = 0; j <= i; j++) begin
        at_or_above = at_or_above | sel[j];
      end
      cmd[i].load     = commit && do_load && (CNT_W'(i) == count);
      cmd[i].shift    = commit && do_remove && at_or_above;
      cmd[i].set_prio = commit && do_reprio && hit[i];
    end
  end

  always_comb begin
    count_next = count;
    if (commit && do_load) count_next = count + CNT_W'(1);
    else if (commit && do_remove) count_next = count - CNT_W'(1);
  end

  // Packed response word; the pad bits stay zero.
  always_comb begin
    res_word = '0;
    res_word[STATUS_W-1:0]                 = res_status;
    res_word[OUT_ID_LSB +: ID_FIELD_W]     = ID_FIELD_W'(res_id);
    res_word[OUT_PRIO_LSB +: PRIO_FIELD_W] = PRIO_FIELD_W'(res_prio);
    res_word[OUT_OCC_LSB +: OCC_W]         = OCC_W'(count_next);
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= res_word;
    end
  end

endmodule

`default_nettype wire

[rtl/fmq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module fmq_checker
  import fmq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // A held response keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("response changed while stalled");

  // Only one request is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in work");

  // A failed request reports no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STATUS_W-1:0] != STAT_OK)
      |-> (m_tdata[OUT_OCC_LSB-1:OUT_ID_LSB] == '0))
    else $error("failed request carries an entry");

  // The reported occupancy never exceeds the row length.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(m_tdata[OUT_OCC_LSB +: OCC_W]) <= DEPTH))
    else $error("occupancy beyond queue depth");

  // No response is pending right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind fifo_tiebreak_max_priority_queue fmq_checker u_fmq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
